/* rtl/core/ps2mt_pkg.sv */
// shared constants, types and helpers for the ps/2 mouse packet tracker
package ps2mt_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = 13;
  localparam int BYTE_BITS  = 8;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam int CMP_BITS   = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int SUM_BITS   = COORD_BITS + 2;
  localparam int DELTA_BITS = BYTE_BITS + 1;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int POS_X_INIT = 400;
  localparam int POS_Y_INIT = 300;

  localparam logic [COORD_BITS-1:0] POS_X_RST =
    COORD_BITS'((POS_X_INIT > COORD_MAX) ? COORD_MAX : POS_X_INIT);
  localparam logic [COORD_BITS-1:0] POS_Y_RST =
    COORD_BITS'((POS_Y_INIT > COORD_MAX) ? COORD_MAX : POS_Y_INIT);

  localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(800);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(600);

  // flag byte bit positions
  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;

  // register index, taken from paddr bit 2
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_FLAGS = 3'b001,
    ST_DX    = 3'b010,
    ST_DY    = 3'b100
  } byte_state_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] flags;
    logic [BYTE_BITS-1:0] dx;
    logic [BYTE_BITS-1:0] dy;
  } pkt_t;

  // largest legal coordinate for a screen size: size 0 acts as 1
  function automatic logic [COORD_BITS-1:0] upper_bound(input logic [SIZE_BITS-1:0] size);
    logic [CMP_BITS-1:0] m;
    m = (size == '0) ? '0 : (CMP_BITS'(size) - CMP_BITS'(1));
    if (m > CMP_BITS'(COORD_MAX)) begin
      m = CMP_BITS'(COORD_MAX);
    end
    return m[COORD_BITS-1:0];
  endfunction

endpackage

/* rtl/core/ps2mt_ifs.sv */
// valid/ready channel interfaces for mouse bytes and cursor words
interface ps2mt_byte_if;
  import ps2mt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_pos_if;
  import ps2mt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [BYTE_BITS-1:0]  flags_byte;
  modport source (output valid, output cursor_x, output cursor_y, output flags_byte,
                  input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input flags_byte,
                output ready);
endinterface

/* rtl/core/ps2mt_front.sv */
// packet framer: syncs on the flags byte and collects three-byte packets
module ps2mt_front (
  input  logic              clk,
  input  logic              rst,
  ps2mt_byte_if.sink        rx,
  input  logic              push_ready,
  output logic              push_valid,
  output ps2mt_pkg::pkt_t   push_pkt
);
  import ps2mt_pkg::*;

  byte_state_t          state;
  byte_state_t          state_next;
  logic [BYTE_BITS-1:0] held_flags;
  logic [BYTE_BITS-1:0] held_dx;
  logic                 take;

  assign rx.ready = push_ready;
  assign take     = rx.valid && rx.ready;

  always_comb begin
    state_next = state;
    push_valid = 1'b0;
    unique case (state)
      ST_DX: begin
        if (take) state_next = ST_DY;
      end
      ST_DY: begin
        push_valid = take;
        if (take) state_next = ST_FLAGS;
      end
      default: begin
        // stray bytes without the sync bit are dropped here
        if (take && rx.rx_byte[SYNC_BIT]) state_next = ST_DX;
      end
    endcase
  end

  assign push_pkt.flags = held_flags;
  assign push_pkt.dx    = held_dx;
  assign push_pkt.dy    = rx.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FLAGS;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && state == ST_DX) held_dx <= rx.rx_byte;
    if (take && state != ST_DX && state != ST_DY && rx.rx_byte[SYNC_BIT]) begin
      held_flags <= rx.rx_byte;
    end
  end

endmodule

/* rtl/core/ps2mt_fifo.sv */
// two-entry packet queue between framer and position update
module ps2mt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  ps2mt_pkg::pkt_t push_pkt,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output ps2mt_pkg::pkt_t pop_pkt
);
  import ps2mt_pkg::*;

  pkt_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign push       = push_valid && push_ready;
  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_pkt    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_pkt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("packet queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("packet queue popped while empty");
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 2'd1)
    else $error("packet queue lost a pushed packet");
`endif

endmodule

/* rtl/core/ps2mt_back.sv */
// position update: applies packet deltas, clamps, holds the result word
module ps2mt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pkt_valid,
  input  ps2mt_pkg::pkt_t                 pkt,
  output logic                            pop,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0] screen_width,
  input  logic [ps2mt_pkg::SIZE_BITS-1:0] screen_height,
  ps2mt_pos_if.source                     cursor
);
  import ps2mt_pkg::*;

  logic [COORD_BITS-1:0]      pos_x;
  logic [COORD_BITS-1:0]      pos_y;
  logic [BYTE_BITS-1:0]       flags;
  logic                       out_valid;
  logic [COORD_BITS-1:0]      hi_x;
  logic [COORD_BITS-1:0]      hi_y;
  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic [COORD_BITS-1:0]      pos_x_next;
  logic [COORD_BITS-1:0]      pos_y_next;

  assign pop = pkt_valid && (!out_valid || cursor.ready);

  assign hi_x = upper_bound(screen_width);
  assign hi_y = upper_bound(screen_height);

  // nine-bit deltas: sign from the flags byte, magnitude byte as sent
  assign dx = {pkt.flags[XSIGN_BIT], pkt.dx};
  assign dy = {pkt.flags[YSIGN_BIT], pkt.dy};

  assign sum_x = $signed({2'b00, pos_x}) + SUM_BITS'(dx);
  assign sum_y = $signed({2'b00, pos_y}) - SUM_BITS'(dy);

  always_comb begin
    priority if (sum_x < 0) begin
      pos_x_next = '0;
    end else if (sum_x > $signed({2'b00, hi_x})) begin
      pos_x_next = hi_x;
    end else begin
      pos_x_next = sum_x[COORD_BITS-1:0];
    end
    priority if (sum_y < 0) begin
      pos_y_next = '0;
    end else if (sum_y > $signed({2'b00, hi_y})) begin
      pos_y_next = hi_y;
    end else begin
      pos_y_next = sum_y[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_X_RST;
      pos_y     <= POS_Y_RST;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (cursor.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) flags <= pkt.flags;
  end

  // position only moves on a pop, which also loads the word, so it doubles as output
  assign cursor.valid      = out_valid;
  assign cursor.cursor_x   = pos_x;
  assign cursor.cursor_y   = pos_y;
  assign cursor.flags_byte = flags;

`ifndef SYNTHESIS
  a_pop_shows: assert property (@(posedge clk) disable iff (rst) pop |=> out_valid)
    else $error("popped packet did not reach the output word");
  a_hold_pos: assert property (@(posedge clk) disable iff (rst)
      !$past(pop) |-> $stable(pos_x) && $stable(pos_y))
    else $error("position moved without a packet");
`endif

endmodule

/* rtl/core/ps2_mouse_packet_tracker.sv */
// top level of the ps/2 mouse packet tracker with its apb register port
// Takes received ps/2 mouse bytes on rx, one byte per accepted handshake, and tracks a
// clamped cursor position. A byte with bit 3 clear is dropped when it would start a
// packet; otherwise it is the flags byte, followed by the x and y delta bytes. Each delta
// is nine bits: the byte as an unsigned magnitude-like value with flags bit 4 (x) or
// bit 5 (y) as its sign bit. x adds the delta, y subtracts it (screen-down positive), and
// both clamp to 0 .. min(size-1, 4095), a size of 0 as 1. Overflow bits pass through in the
// flags byte only. One cursor word (cursor_x, cursor_y, flags_byte) leaves per packet.
// Rate: one byte per clock; the framer, a two-entry packet queue and the position
// update with its output word run on their own, so a stalled cursor sink only blocks rx
// once the output word and two queued packets are waiting. After its third byte is accepted,
// a packet waits in the queue until it is popped into the output word. Position resets to (400, 300).
// Registers: screen_width at byte address 0, screen_height at 4, 13 bits each, reset
// 800 and 600; write them only while the block is idle. pready is always high; reads
// return the stored value.
module ps2_mouse_packet_tracker (
  input  logic                            clk,
  input  logic                            rst,
  ps2mt_byte_if.sink                      rx,
  ps2mt_pos_if.source                     cursor,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ps2mt_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ps2mt_pkg::DATA_BITS-1:0] pwdata,
  output logic [ps2mt_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready
);
  import ps2mt_pkg::*;

  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;
  logic                 reg_write;
  logic                 reg_sel;

  logic                 push_valid;
  logic                 push_ready;
  pkt_t                 push_pkt;
  logic                 pop;
  logic                 pop_valid;
  pkt_t                 pop_pkt;

  // register port: single-beat access, index from address bit 2
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // framer: sync on the flags byte, gather three bytes per packet
  ps2mt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_pkt   (push_pkt)
  );

  // short queue so the framer keeps taking bytes while a cursor word waits
  ps2mt_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_pkt   (push_pkt),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_pkt    (pop_pkt)
  );

  // delta add, clamp and output word
  ps2mt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pkt_valid     (pop_valid),
    .pkt           (pop_pkt),
    .pop           (pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .cursor        (cursor)
  );

endmodule

/* bench/testbench.sv */
// self-checking bench for the ps/2 mouse packet tracker: directed packets, then random byte streams
`timescale 1ns / 100ps

module testbench;
  import ps2mt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;    // margin for the pipe to empty after the last due word is taken
  localparam int PHASE_BYTES   = 100;  // counted bytes per random phase
  localparam int RANDOM_PHASES = 7;
  localparam int DIRECTED_LEN  = 26;

  // one cursor word as the block emits it
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BYTE_BITS-1:0]  flags;
  } cursor_word_t;

  // directed row: the byte, and for obvious cases the word it must complete
  typedef struct packed {
    logic [BYTE_BITS-1:0]  rx_byte;
    logic                  typed;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BYTE_BITS-1:0]  flags;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  ps2mt_byte_if rx_if ();
  ps2mt_pos_if  cur_if ();

  ps2_mouse_packet_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .cursor  (cur_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tracker mirror: framing state, held bytes, position and screen size
  byte_state_t          pkt_state;
  logic [BYTE_BITS-1:0] held_flags;
  logic [BYTE_BITS-1:0] held_dx;
  int                   pos_x;
  int                   pos_y;
  logic [SIZE_BITS-1:0] scr_w;
  logic [SIZE_BITS-1:0] scr_h;

  cursor_word_t  cursor_words_due[$];
  directed_row_t directed_rows[DIRECTED_LEN];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  // largest legal coordinate: a size of 0 behaves as 1, and the bound saturates at the
  // coordinate range
  function automatic int max_coord(input logic [SIZE_BITS-1:0] size);
    int s;
    s = int'(size);
    if (s < 1) s = 1;
    return (s - 1 > COORD_MAX) ? COORD_MAX : s - 1;
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the mirror by one byte; returns 1 when the byte completes a packet
  function automatic bit track_mouse_byte(input logic [BYTE_BITS-1:0] b,
                                          output cursor_word_t w);
    int dx;
    int dy;
    w = '0;
    case (pkt_state)
      ST_DX: begin
        held_dx = b;
        pkt_state = ST_DY;
        return 1'b0;
      end
      ST_DY: begin
        // nine-bit deltas: unsigned byte with the sign bit taken from the flags byte
        dx = int'(held_dx) - (held_flags[XSIGN_BIT] ? 256 : 0);
        dy = int'(b) - (held_flags[YSIGN_BIT] ? 256 : 0);
        // y grows downward on screen, so the mouse's up-positive delta is subtracted
        pos_x = clamp_coord(pos_x + dx, max_coord(scr_w));
        pos_y = clamp_coord(pos_y - dy, max_coord(scr_h));
        pkt_state = ST_FLAGS;
        w.x = pos_x[COORD_BITS-1:0];
        w.y = pos_y[COORD_BITS-1:0];
        w.flags = held_flags;
        return 1'b1;
      end
      default: begin
        // a byte without the sync bit cannot open a packet and is dropped
        pkt_state = ST_FLAGS;
        if (b[SYNC_BIT]) begin
          held_flags = b;
          pkt_state = ST_DX;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // offer one byte on rx, with random gaps, and return once it has been accepted
  task automatic feed_byte(input logic [BYTE_BITS-1:0] b, input bit use_typed,
                           input cursor_word_t typed_word, output bit dropped);
    cursor_word_t w;
    bit           has_word;
    dropped = (pkt_state == ST_FLAGS) && !b[SYNC_BIT];
    has_word = track_mouse_byte(b, w);
    if (has_word) begin
      cursor_words_due.push_back(use_typed ? typed_word : w);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  // register write: setup phase, then access phase until pready, then idle
  task automatic write_screen_reg(input logic reg_sel, input logic [SIZE_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'({reg_sel, 2'b00});
    // junk above the 13 size bits must be ignored
    pwdata <= ($urandom() & ~((32'd1 << SIZE_BITS) - 32'd1)) | DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_SCREEN_WIDTH) scr_w = value;
    else scr_h = value;
    @(posedge clk);
  endtask

  // drain: stop offering bytes, wait for every outstanding word, then let the pipe empty
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (cursor_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cursor side: random back-pressure, and every accepted word checked against the oldest due
  always @(posedge clk) begin
    cursor_word_t got;
    cursor_word_t want;
    if (rst) begin
      cur_if.ready <= 1'b0;
    end else begin
      if (cur_if.valid && cur_if.ready) begin
        got.x = cur_if.cursor_x;
        got.y = cur_if.cursor_y;
        got.flags = cur_if.flags_byte;
        if (cursor_words_due.size() == 0) begin
          $error("cursor word with none due: x=%0d y=%0d flags=%h", got.x, got.y, got.flags);
          mismatch_count++;
        end else begin
          want = cursor_words_due.pop_front();
          if (got.x !== want.x) begin
            $error("cursor_x mismatch: expected %0d, got %0d", want.x, got.x);
            mismatch_count++;
          end
          if (got.y !== want.y) begin
            $error("cursor_y mismatch: expected %0d, got %0d", want.y, got.y);
            mismatch_count++;
          end
          if (got.flags !== want.flags) begin
            $error("flags_byte mismatch: expected %h, got %h", want.flags, got.flags);
            mismatch_count++;
          end
        end
      end
      cur_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cursor_word_t         typed_word;
    logic [BYTE_BITS-1:0] b;
    logic [SIZE_BITS-1:0] w_set;
    logic [SIZE_BITS-1:0] h_set;
    bit                   dropped;
    int                   fed;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= '0;

    pkt_state = ST_FLAGS;
    held_flags = '0;
    held_dx = '0;
    pos_x = int'(POS_X_RST);
    pos_y = int'(POS_Y_RST);
    scr_w = WIDTH_RST;
    scr_h = HEIGHT_RST;

    // directed packets on the reset screen of 800 x 600, starting from (400, 300)
    directed_rows = '{
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},  // no sync bit: dropped
      '{8'hF7, 1'b0, 12'd0,   12'd0,   8'h00},  // every bit but sync: dropped
      '{8'h08, 1'b0, 12'd0,   12'd0,   8'h00},  // zero move reports the reset position
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd400, 12'd300, 8'h08},
      '{8'h08, 1'b0, 12'd0,   12'd0,   8'h00},  // largest positive x step
      '{8'hFF, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd655, 12'd300, 8'h08},
      '{8'h18, 1'b0, 12'd0,   12'd0,   8'h00},  // most negative x step
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd399, 12'd300, 8'h18},
      '{8'h28, 1'b0, 12'd0,   12'd0,   8'h00},  // most negative y step moves down
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd399, 12'd556, 8'h28},
      '{8'h38, 1'b0, 12'd0,   12'd0,   8'h00},  // y runs into the bottom edge
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd143, 12'd599, 8'h38},
      '{8'h38, 1'b0, 12'd0,   12'd0,   8'h00},  // x runs into the left edge
      '{8'h00, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'h00, 1'b1, 12'd0,   12'd599, 8'h38},
      '{8'hC8, 1'b0, 12'd0,   12'd0,   8'h00},  // overflow bits pass through untouched
      '{8'hFF, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'hFF, 1'b1, 12'd255, 12'd344, 8'hC8},
      '{8'hFF, 1'b0, 12'd0,   12'd0,   8'h00},  // all-ones packet: minus one on both axes
      '{8'hFF, 1'b0, 12'd0,   12'd0,   8'h00},
      '{8'hFF, 1'b0, 12'd0,   12'd0,   8'h00}
    };

    send_idle_pct = 21;
    recv_idle_pct = 81;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_word.x = directed_rows[i].x;
      typed_word.y = directed_rows[i].y;
      typed_word.flags = directed_rows[i].flags;
      feed_byte(directed_rows[i].rx_byte, directed_rows[i].typed, typed_word, dropped);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      // screen sizes per phase: reset values, zero size, beyond the coordinate range,
      // a shrunken screen that leaves the cursor outside, one-pixel axes, then random
      case (ph)
        0: begin w_set = 13'd800;  h_set = 13'd600;  end
        1: begin w_set = 13'd0;    h_set = 13'd0;    end
        2: begin w_set = 13'd8191; h_set = 13'd4096; end
        3: begin w_set = 13'd100;  h_set = 13'd50;   end
        4: begin w_set = 13'd1;    h_set = 13'd8191; end
        5: begin w_set = 13'd4096; h_set = 13'd1;    end
        default: begin
          w_set = SIZE_BITS'($urandom_range(0, 8191));
          h_set = SIZE_BITS'($urandom_range(0, 8191));
        end
      endcase
      write_screen_reg(REG_SCREEN_WIDTH, w_set);
      write_screen_reg(REG_SCREEN_HEIGHT, h_set);

      // idling: slow receiver first, then slow sender, then full speed both ways
      if (ph < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 81;
      end else if (ph < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // mostly whole packets with random content; stray bytes knock the framing around
      fed = 0;
      while (fed < PHASE_BYTES) begin
        if ($urandom_range(99) < 85) begin
          for (int k = 0; k < 3; k++) begin
            b = BYTE_BITS'($urandom_range(0, 255));
            if (k == 0) b[SYNC_BIT] = 1'b1;
            feed_byte(b, 1'b0, '0, dropped);
            if (!dropped) fed++;
          end
        end else begin
          feed_byte(BYTE_BITS'($urandom_range(0, 255)), 1'b0, '0, dropped);
          if (!dropped) fed++;
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ps2mt_pkg.sv
rtl/core/ps2mt_ifs.sv
rtl/core/ps2mt_front.sv
rtl/core/ps2mt_fifo.sv
rtl/core/ps2mt_back.sv
rtl/core/ps2_mouse_packet_tracker.sv
bench/testbench.sv
